// File: rtl/q2r_pkg.sv
`timescale 1ns / 1ps
package q2r_pkg;
   localparam int IN_WIDTH  = 16;
   localparam int FRAC_BITS = 14;
   localparam int OUT_WIDTH = 16;
   localparam int PROD_WIDTH = 2 * IN_WIDTH;
   localparam int NORM_WIDTH = PROD_WIDTH + 2;
   localparam int NUM_WIDTH  = PROD_WIDTH + 3;
   localparam int QUO_WIDTH  = FRAC_BITS + 2;
   localparam int NUM_ENTRIES = 9;

   typedef struct packed {
      logic signed [IN_WIDTH-1:0] quat_w;
      logic signed [IN_WIDTH-1:0] quat_x;
      logic signed [IN_WIDTH-1:0] quat_y;
      logic signed [IN_WIDTH-1:0] quat_z;
   } req_type;

   typedef struct packed {
      logic signed [OUT_WIDTH-1:0] m00;
      logic signed [OUT_WIDTH-1:0] m01;
      logic signed [OUT_WIDTH-1:0] m02;
      logic signed [OUT_WIDTH-1:0] m10;
      logic signed [OUT_WIDTH-1:0] m11;
      logic signed [OUT_WIDTH-1:0] m12;
      logic signed [OUT_WIDTH-1:0] m20;
      logic signed [OUT_WIDTH-1:0] m21;
      logic signed [OUT_WIDTH-1:0] m22;
      logic                        zero_error;
   } rsp_type;

   // magnitude form of one numerator
   typedef struct packed {
      logic                 neg;
      logic [NUM_WIDTH-1:0] mag;
   } num_type;

   typedef num_type [NUM_ENTRIES-1:0] num_vec_type;
endpackage

// File: rtl/quaternion_to_rotation_matrix.sv
`timescale 1ns / 1ps
// Quaternion to 3x3 rotation matrix.
// req channel: one quaternion (w, x, y, z), signed 16-bit, any common scale.
// rsp channel: nine entries, signed Q1.14, row-major, rounded to nearest
//   (ties away from zero), plus zero_error for an all-zero quaternion, in
//   which case every entry is zero.
// No square root: each entry is a numerator over n = w^2+x^2+y^2+z^2,
//   divided by a pipelined restoring divider, one quotient bit per stage.
// Pipeline: 2 product/sum stages, 16 divider stages and 1 output register
//   lie between a req beat and rsp valid.
// Throughput: one beat per cycle while the pipe is not stalled; the whole pipe is one shift chain.
// Stall: when rsp_stall is high and the output register holds a beat, the
//   pipe freezes and req_stall rises; no beat is lost or repeated. Every
//   stage freezes at once, so bubbles already in the pipe stay in place.
// Reset: all valid bits clear; the block is ready the next cycle.
module quaternion_to_rotation_matrix (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  q2r_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output q2r_pkg::rsp_type  rsp_data
);
   import q2r_pkg::*;

   logic        advance;
   logic        prod_valid, div_valid;
   num_vec_type prod_num;
   logic [NORM_WIDTH-1:0] prod_norm;
   rsp_type     div_data;
   logic        out_valid_ff;
   rsp_type     out_data_ff;

   // pipe moves whenever the output register is free or being emptied
   assign advance   = !out_valid_ff || !rsp_stall;
   assign req_stall = !advance;

   q2r_products u_products (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_valid),
      .in_data   (req_data),
      .out_valid (prod_valid),
      .out_num   (prod_num),
      .out_norm  (prod_norm)
   );

   q2r_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (prod_valid),
      .in_num    (prod_num),
      .in_norm   (prod_norm),
      .out_valid (div_valid),
      .out_data  (div_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= div_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_data_ff <= div_data;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("rsp beat changed under stall");
   a_stall: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("req stalled without rsp back-pressure");
   a_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.zero_error |-> rsp_data.m00 == '0 && rsp_data.m11 == '0
         && rsp_data.m22 == '0)
      else $error("zero quaternion gave nonzero entries");
endmodule

// File: rtl/q2r_products.sv
`timescale 1ns / 1ps
// Two stages: all ten products, then norm and the nine signed numerators.
module q2r_products (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           advance,
   input  logic                           in_valid,
   input  q2r_pkg::req_type               in_data,
   output logic                           out_valid,
   output q2r_pkg::num_vec_type           out_num,
   output logic [q2r_pkg::NORM_WIDTH-1:0] out_norm
);
   import q2r_pkg::*;

   localparam int SW = NUM_WIDTH + 1;

   logic signed [PROD_WIDTH-1:0] ww_ff, xx_ff, yy_ff, zz_ff, xy_ff, xz_ff, yz_ff;
   logic signed [PROD_WIDTH-1:0] wx_ff, wy_ff, wz_ff;
   logic                         v1_ff, v2_ff;
   num_vec_type                  num_ff, num_in;
   logic [NORM_WIDTH-1:0]        norm_ff, norm_in;
   logic signed [SW-1:0]         s_ww, s_xx, s_yy, s_zz, s_xy, s_xz, s_yz;
   logic signed [SW-1:0]         s_wx, s_wy, s_wz;
   logic signed [SW-1:0]         val [NUM_ENTRIES];

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         ww_ff <= in_data.quat_w * in_data.quat_w;
         xx_ff <= in_data.quat_x * in_data.quat_x;
         yy_ff <= in_data.quat_y * in_data.quat_y;
         zz_ff <= in_data.quat_z * in_data.quat_z;
         xy_ff <= in_data.quat_x * in_data.quat_y;
         xz_ff <= in_data.quat_x * in_data.quat_z;
         yz_ff <= in_data.quat_y * in_data.quat_z;
         wx_ff <= in_data.quat_w * in_data.quat_x;
         wy_ff <= in_data.quat_w * in_data.quat_y;
         wz_ff <= in_data.quat_w * in_data.quat_z;
         num_ff  <= num_in;
         norm_ff <= norm_in;
      end
   end

   // squares are non-negative, so they are widened through the unsigned view
   assign s_ww = SW'($unsigned(ww_ff));
   assign s_xx = SW'($unsigned(xx_ff));
   assign s_yy = SW'($unsigned(yy_ff));
   assign s_zz = SW'($unsigned(zz_ff));
   assign s_xy = SW'(xy_ff);
   assign s_xz = SW'(xz_ff);
   assign s_yz = SW'(yz_ff);
   assign s_wx = SW'(wx_ff);
   assign s_wy = SW'(wy_ff);
   assign s_wz = SW'(wz_ff);

   always_comb begin
      norm_in = NORM_WIDTH'($unsigned(ww_ff)) + NORM_WIDTH'($unsigned(xx_ff))
              + NORM_WIDTH'($unsigned(yy_ff)) + NORM_WIDTH'($unsigned(zz_ff));
      val[0] = s_ww + s_xx - s_yy - s_zz;
      val[1] = (s_xy - s_wz) <<< 1;
      val[2] = (s_xz + s_wy) <<< 1;
      val[3] = (s_xy + s_wz) <<< 1;
      val[4] = s_ww + s_yy - s_xx - s_zz;
      val[5] = (s_yz - s_wx) <<< 1;
      val[6] = (s_xz - s_wy) <<< 1;
      val[7] = (s_yz + s_wx) <<< 1;
      val[8] = s_ww + s_zz - s_xx - s_yy;
      for (int k = 0; k < NUM_ENTRIES; k++) begin
         num_in[k].neg = val[k][SW-1];
         num_in[k].mag = val[k][SW-1] ? NUM_WIDTH'(-val[k]) : NUM_WIDTH'(val[k]);
      end
   end

   assign out_valid = v2_ff;
   assign out_num   = num_ff;
   assign out_norm  = norm_ff;
endmodule

// File: rtl/q2r_divider.sv
`timescale 1ns / 1ps
// Pipelined restoring divider for nine lanes: one quotient bit per stage.
module q2r_divider (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           advance,
   input  logic                           in_valid,
   input  q2r_pkg::num_vec_type           in_num,
   input  logic [q2r_pkg::NORM_WIDTH-1:0] in_norm,
   output logic                           out_valid,
   output q2r_pkg::rsp_type               out_data
);
   import q2r_pkg::*;

   localparam int STAGES = FRAC_BITS + 2;   // integer bit, fraction bits, round bit
   localparam int RW     = NUM_WIDTH + 1;

   // stage s result sits at index s; the last stage keeps no remainder
   logic [RW-1:0]         rem_ff  [STAGES-1][NUM_ENTRIES];
   logic [QUO_WIDTH-1:0]  quo_ff  [STAGES][NUM_ENTRIES];
   logic                  neg_ff  [STAGES][NUM_ENTRIES];
   logic [NORM_WIDTH-1:0] den_ff  [STAGES];
   logic                  vld_ff  [STAGES];
   logic [OUT_WIDTH-1:0]  ent     [NUM_ENTRIES];
   logic [QUO_WIDTH-1:0]  rounded [NUM_ENTRIES];
   logic                  zero_q;

   for (genvar s = 0; s < STAGES; s++) begin : g_stage
      logic [RW-1:0]         rem_src [NUM_ENTRIES];
      logic [QUO_WIDTH-1:0]  quo_src [NUM_ENTRIES];
      logic                  neg_src [NUM_ENTRIES];
      logic [NORM_WIDTH-1:0] den_src;
      logic                  vld_src;
      logic [RW-1:0]         shifted [NUM_ENTRIES];
      logic                  take    [NUM_ENTRIES];

      if (s == 0) begin : g_first
         always_comb begin
            for (int k = 0; k < NUM_ENTRIES; k++) begin
               rem_src[k] = RW'(in_num[k].mag);
               quo_src[k] = '0;
               neg_src[k] = in_num[k].neg;
            end
            den_src = in_norm;
            vld_src = in_valid;
         end
      end else begin : g_next
         always_comb begin
            for (int k = 0; k < NUM_ENTRIES; k++) begin
               rem_src[k] = rem_ff[s-1][k];
               quo_src[k] = quo_ff[s-1][k];
               neg_src[k] = neg_ff[s-1][k];
            end
            den_src = den_ff[s-1];
            vld_src = vld_ff[s-1];
         end
      end

      always_comb begin
         for (int k = 0; k < NUM_ENTRIES; k++) begin
            shifted[k] = (s == 0) ? rem_src[k] : (rem_src[k] << 1);
            take[k]    = (shifted[k] >= RW'(den_src));
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else if (advance) begin
            vld_ff[s] <= vld_src;
         end
      end

      // quotient bit of this stage lands at its own position, MSB first
      always_ff @(posedge clock) begin
         if (advance) begin
            den_ff[s] <= den_src;
            for (int k = 0; k < NUM_ENTRIES; k++) begin
               neg_ff[s][k] <= neg_src[k];
               quo_ff[s][k] <= quo_src[k] | (QUO_WIDTH'(take[k]) << (STAGES - 1 - s));
            end
         end
      end

      if (s < STAGES - 1) begin : g_rem
         always_ff @(posedge clock) begin
            if (advance) begin
               for (int k = 0; k < NUM_ENTRIES; k++) begin
                  rem_ff[s][k] <= take[k] ? (shifted[k] - RW'(den_src)) : shifted[k];
               end
            end
         end
      end
   end

   // last bit is the round bit: half or more rounds away from zero
   always_comb begin
      zero_q = (den_ff[STAGES-1] == '0);
      for (int k = 0; k < NUM_ENTRIES; k++) begin
         rounded[k] = {1'b0, quo_ff[STAGES-1][k][QUO_WIDTH-1:1]}
                    + QUO_WIDTH'(quo_ff[STAGES-1][k][0]);
         ent[k] = OUT_WIDTH'(neg_ff[STAGES-1][k] ? -rounded[k] : rounded[k]);
         if (zero_q) ent[k] = '0;
      end
   end

   assign out_valid = vld_ff[STAGES-1];
   assign out_data  = '{m00: ent[0], m01: ent[1], m02: ent[2], m10: ent[3], m11: ent[4],
                        m12: ent[5], m20: ent[6], m21: ent[7], m22: ent[8],
                        zero_error: zero_q};
endmodule
